// ----- rtl/tdp_pkg.sv -----
// Shared types, constants and microcode program of the trial-division prime tester.
package tdp_pkg;

	// Width of the tested number and derived datapath widths
	localparam int NUM_WIDTH      = 16;
	localparam int DIV_W          = NUM_WIDTH / 2 + 1;
	localparam int SQ_W           = 2 * DIV_W;
	localparam int BIT_W          = $clog2(NUM_WIDTH);
	localparam int CNT_W          = 8;
	localparam int PRIME_DIVISORS = 2;
	localparam int STEP_W         = 3;

	typedef logic [STEP_W-1:0] step_t;

	// Datapath operations, one per control word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQUARE,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_ACCUM,
		OP_EMIT
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_SQ_GT_N,
		C_BIT_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	// Program steps
	localparam step_t S_LOAD     = 3'd0;
	localparam step_t S_SQUARE   = 3'd1;
	localparam step_t S_TEST     = 3'd2;
	localparam step_t S_DIV_INIT = 3'd3;
	localparam step_t S_DIV_STEP = 3'd4;
	localparam step_t S_ACCUM    = 3'd5;
	localparam step_t S_EMIT     = 3'd6;
	localparam step_t S_RETURN   = 3'd7;

	// Strobes from the sequencer into the datapath
	typedef struct packed {
		logic load;
		logic square;
		logic div_init;
		logic div_step;
		logic accum;
	} dp_ctrl_t;

	// Flags and results from the datapath back to the sequencer
	typedef struct packed {
		logic             sq_gt_n;
		logic             bit_more;
		logic             prime;
		logic [CNT_W-1:0] count;
	} dp_stat_t;

	// Microcode: one control word per step; jump to target when cond holds
	function automatic ctrl_word_t tdp_rom(step_t step);
		ctrl_word_t w;
		begin
			unique case (step)
				S_LOAD:     w = '{OP_LOAD,     C_NO_INPUT, S_LOAD};
				S_SQUARE:   w = '{OP_SQUARE,   C_NEVER,    S_LOAD};
				S_TEST:     w = '{OP_NOP,      C_SQ_GT_N,  S_EMIT};
				S_DIV_INIT: w = '{OP_DIV_INIT, C_NEVER,    S_LOAD};
				S_DIV_STEP: w = '{OP_DIV_STEP, C_BIT_MORE, S_DIV_STEP};
				S_ACCUM:    w = '{OP_ACCUM,    C_ALWAYS,   S_SQUARE};
				S_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY, S_EMIT};
				S_RETURN:   w = '{OP_NOP,      C_ALWAYS,   S_LOAD};
				default:    w = '{OP_NOP,      C_ALWAYS,   S_LOAD};
			endcase
			return w;
		end
	endfunction

endpackage

// ----- rtl/tdp_datapath.sv -----
// Datapath of the prime tester: candidate, square, bit-serial remainder and divisor count.
module tdp_datapath import tdp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_ctrl_t             ctrl,
	input  logic [NUM_WIDTH-1:0] number,
	output dp_stat_t             stat
);

	logic [NUM_WIDTH-1:0] n_q;
	logic [DIV_W-1:0]     d_q;
	logic [SQ_W-1:0]      sq_q;
	logic [DIV_W-1:0]     rem_q;
	logic [BIT_W-1:0]     bit_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       reduced;
	logic [CNT_W:0]       cnt_sum;
	logic [1:0]           cnt_inc;

	// One restoring division step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, n_q[bit_q]};
		reduced = shifted - {1'b0, d_q};
		if (shifted >= {1'b0, d_q}) begin
			shifted = reduced;
		end
	end

	// A divisor below the root pairs with its cofactor; the root counts once
	always_comb begin
		cnt_inc = (sq_q == SQ_W'(n_q)) ? 2'd1 : 2'd2;
		cnt_sum = {1'b0, cnt_q} + {{(CNT_W-1){1'b0}}, cnt_inc};
	end

	// Hold the working registers; advance them as the program steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			d_q   <= '0;
			sq_q  <= '0;
			rem_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
		end else begin
			if (ctrl.load) begin
				n_q   <= number;
				d_q   <= DIV_W'(1);
				cnt_q <= '0;
			end
			if (ctrl.square) begin
				sq_q <= SQ_W'(d_q) * SQ_W'(d_q);
			end
			if (ctrl.div_init) begin
				rem_q <= '0;
				bit_q <= BIT_W'(NUM_WIDTH - 1);
			end
			if (ctrl.div_step) begin
				rem_q <= shifted[DIV_W-1:0];
				bit_q <= bit_q - BIT_W'(1);
			end
			if (ctrl.accum) begin
				d_q <= d_q + DIV_W'(1);
				if (rem_q == '0) begin
					cnt_q <= cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
				end
			end
		end
	end

	// Report flags and the finished count
	assign stat.sq_gt_n  = sq_q > SQ_W'(n_q);
	assign stat.bit_more = bit_q != '0;
	assign stat.prime    = cnt_q == CNT_W'(PRIME_DIVISORS);
	assign stat.count    = cnt_q;

endmodule

// ----- rtl/trial_division_prime_test.sv -----
// Top level of the trial-division prime tester: microcode sequencer and output register.
//
// Usage:
//   Input channel (in_valid, in_stall, number): one 16-bit unsigned number per
//   transfer. in_stall is low only while the sequencer waits at its load step.
//   Output channel (out_valid, out_stall, is_prime, divisor_count): one result
//   per input, held in an output register until the receiver takes it.
//   Work: candidates d = 1, 2, ... are tried while d*d <= number. Each
//   candidate runs the square, test, remainder setup, remainder (one bit
//   per cycle) and accumulate steps in turn.
//   One number is worked on at a time; after the result is written, the
//   sequencer passes its return step and goes back to the load step,
//   where the next number can be taken.
//   The next number is taken while the previous result still waits.
//   If the receiver stalls and a new result is ready, the sequencer holds at
//   its emit step until the output register frees up.
//   Reset (arst_n low) returns the sequencer to the load step and empties the
//   output register.
module trial_division_prime_test import tdp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [NUM_WIDTH-1:0] number,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 is_prime,
	output logic [CNT_W-1:0]     divisor_count
);

	step_t      step_q;
	ctrl_word_t cw;
	dp_ctrl_t   dp_ctrl;
	dp_stat_t   dp_stat;
	logic       out_busy;
	logic       cond_true;
	logic       emit;
	logic       out_valid_q;
	logic       is_prime_q;
	logic [CNT_W-1:0] count_q;

	assign cw       = tdp_rom(step_q);
	assign out_busy = out_valid_q && out_stall;
	assign in_stall = step_q != S_LOAD;
	assign emit     = (cw.op == OP_EMIT) && !out_busy;

	// Decode the control word into datapath strobes
	always_comb begin
		dp_ctrl = '0;
		unique case (cw.op) inside
			OP_LOAD:     dp_ctrl.load     = in_valid;
			OP_SQUARE:   dp_ctrl.square   = 1'b1;
			OP_DIV_INIT: dp_ctrl.div_init = 1'b1;
			OP_DIV_STEP: dp_ctrl.div_step = 1'b1;
			OP_ACCUM:    dp_ctrl.accum    = 1'b1;
			OP_NOP, OP_EMIT: ;
			default: ;
		endcase
	end

	// Evaluate the jump condition
	always_comb begin
		unique case (cw.cond)
			C_NEVER:    cond_true = 1'b0;
			C_ALWAYS:   cond_true = 1'b1;
			C_NO_INPUT: cond_true = !in_valid;
			C_SQ_GT_N:  cond_true = dp_stat.sq_gt_n;
			C_BIT_MORE: cond_true = dp_stat.bit_more;
			C_OUT_BUSY: cond_true = out_busy;
			default:    cond_true = 1'b1;
		endcase
	end

	// Advance the step counter or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_LOAD;
		end else if (cond_true) begin
			step_q <= cw.target;
		end else begin
			step_q <= step_q + step_t'(1);
		end
	end

	// Hold the result until the receiver takes it; drop valid after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			is_prime_q <= dp_stat.prime;
			count_q    <= dp_stat.count;
		end
	end

	tdp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dp_ctrl),
		.number (number),
		.stat   (dp_stat)
	);

	assign out_valid     = out_valid_q;
	assign is_prime      = is_prime_q;
	assign divisor_count = count_q;

	// An accepted number always starts the square step
	a_load_to_square: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> step_q == S_SQUARE)
		else $error("accepted number did not start the square step");

	// A waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !out_busy)
		else $error("result written while output stalled");

	// The prime flag agrees with the count
	a_prime_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (is_prime_q == (count_q == CNT_W'(PRIME_DIVISORS))))
		else $error("prime flag disagrees with divisor count");

	// A new result appears only after the emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step_q) == S_EMIT)
		else $error("result valid raised outside emit step");

endmodule
